### rtl/joint_path_length_accumulator_core_defines.svh
// Assertion macros shared by the path length accumulator modules.
`ifndef JOINT_PATH_LENGTH_ACCUMULATOR_CORE_DEFINES_SVH
`define JOINT_PATH_LENGTH_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define JPLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off during rst.
`define JPLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jpla_pkg.sv
// Shared types and field widths of the joint path length accumulator.
package jpla_pkg;

  localparam int ANGLE_W      = 16;
  localparam int JOINT_FIELDS = 6;
  localparam int SEC_W        = 16;
  localparam int NSEC_W       = 30;
  localparam int TALLY_W      = 16;
  localparam int LEN_W        = 32;

  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_LAST   = 2'd1,
    ACT_EMPTY  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // Datapath part of one microcode word.
  typedef struct packed {
    logic take;
    logic mul;
    logic acc_add;
    logic sq_init;
    logic sq_step;
    logic len_add;
    logic commit;
    logic emit;
  } dp_ctrl_t;

  // Flags the sequencer branches on.
  typedef struct packed {
    logic    item_valid;
    action_t action;
    logic    have_prev;
    logic    joint_last;
    logic    sqrt_last;
    logic    out_busy;
  } dp_status_t;

endpackage

### rtl/jpla_sequencer.sv
// Microcode sequencer: step counter, program table and branch conditions.
`include "joint_path_length_accumulator_core_defines.svh"

module jpla_sequencer
  import jpla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_ACT_EMPTY,
    COND_ACT_UNUSED,
    COND_NO_PREV,
    COND_JOINT_MORE,
    COND_SQRT_MORE,
    COND_ACT_POINT,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t            cond;
    logic [PC_W-1:0]  target;
    dp_ctrl_t         dp;
  } uword_t;

  localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] STEP_UNUSED   = 4'd2;
  localparam logic [PC_W-1:0] STEP_PREV     = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL      = 4'd4;
  localparam logic [PC_W-1:0] STEP_ACC      = 4'd5;
  localparam logic [PC_W-1:0] STEP_SQ_INIT  = 4'd6;
  localparam logic [PC_W-1:0] STEP_SQ_STEP  = 4'd7;
  localparam logic [PC_W-1:0] STEP_LEN_ADD  = 4'd8;
  localparam logic [PC_W-1:0] STEP_COMMIT   = 4'd9;
  localparam logic [PC_W-1:0] STEP_EMIT     = 4'd10;
  localparam logic [PC_W-1:0] STEP_RETURN   = 4'd11;
  localparam logic [PC_W-1:0] STEP_LAST     = STEP_RETURN;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            cond_hit;

  // Program table.
  always_comb begin
    uw = '{cond: COND_NEVER, target: STEP_WAIT, dp: '0};
    unique case (pc)
      STEP_WAIT: begin
        uw.dp.take = 1'b1;
        uw.cond    = COND_NO_ITEM;
        uw.target  = STEP_WAIT;
      end
      STEP_DISPATCH: begin
        uw.cond   = COND_ACT_EMPTY;
        uw.target = STEP_EMIT;
      end
      STEP_UNUSED: begin
        uw.cond   = COND_ACT_UNUSED;
        uw.target = STEP_WAIT;
      end
      STEP_PREV: begin
        uw.cond   = COND_NO_PREV;
        uw.target = STEP_COMMIT;
      end
      STEP_MUL: begin
        uw.dp.mul     = 1'b1;
        uw.dp.acc_add = 1'b1;
        uw.cond       = COND_JOINT_MORE;
        uw.target     = STEP_MUL;
      end
      STEP_ACC: begin
        uw.dp.acc_add = 1'b1;
      end
      STEP_SQ_INIT: begin
        uw.dp.sq_init = 1'b1;
      end
      STEP_SQ_STEP: begin
        uw.dp.sq_step = 1'b1;
        uw.cond       = COND_SQRT_MORE;
        uw.target     = STEP_SQ_STEP;
      end
      STEP_LEN_ADD: begin
        uw.dp.len_add = 1'b1;
      end
      STEP_COMMIT: begin
        uw.dp.commit = 1'b1;
        uw.cond      = COND_ACT_POINT;
        uw.target    = STEP_WAIT;
      end
      STEP_EMIT: begin
        uw.dp.emit = 1'b1;
        uw.cond    = COND_OUT_BUSY;
        uw.target  = STEP_EMIT;
      end
      STEP_RETURN: begin
        uw.cond   = COND_ALWAYS;
        uw.target = STEP_WAIT;
      end
      default: begin
        uw.cond   = COND_ALWAYS;
        uw.target = STEP_WAIT;
      end
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:      cond_hit = 1'b0;
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_NO_ITEM:    cond_hit = !status.item_valid;
      COND_ACT_EMPTY:  cond_hit = (status.action == ACT_EMPTY);
      COND_ACT_UNUSED: cond_hit = (status.action == ACT_UNUSED);
      COND_NO_PREV:    cond_hit = !status.have_prev;
      COND_JOINT_MORE: cond_hit = !status.joint_last;
      COND_SQRT_MORE:  cond_hit = !status.sqrt_last;
      COND_ACT_POINT:  cond_hit = (status.action == ACT_POINT);
      COND_OUT_BUSY:   cond_hit = status.out_busy;
      default:         cond_hit = 1'b1;
    endcase
  end

  assign pc_next = cond_hit ? uw.target : pc + 1'b1;
  assign ctrl    = uw.dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  `JPLA_ASSERT_IMP(a_pc_in_program, 1'b1, pc <= STEP_LAST, "step counter left the program")
  `JPLA_ASSERT_NEXT(a_take_dispatch, (pc == STEP_WAIT) && status.item_valid,
    pc == STEP_DISPATCH, "accepted word was not dispatched")

endmodule

### rtl/jpla_datapath.sv
// Datapath: item registers, squared-delta accumulator, bitwise square root, result register.
`include "joint_path_length_accumulator_core_defines.svh"

module jpla_datapath
  import jpla_pkg::*;
#(
  parameter int NUM_JOINTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [1:0]                action,
  input  logic signed [ANGLE_W-1:0] joint_pos [JOINT_FIELDS],
  input  logic [SEC_W-1:0]          time_sec,
  input  logic [NSEC_W-1:0]         time_nsec,
  input  dp_ctrl_t                  ctrl,
  output dp_status_t                status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      valid_res,
  output logic [TALLY_W-1:0]        point_total,
  output logic [SEC_W-1:0]          duration_sec,
  output logic [NSEC_W-1:0]         duration_nsec,
  output logic [LEN_W-1:0]          path_length
);

  localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int SQ_W   = 2 * ANGLE_W;
  // Sum of up to eight squares of 16-bit magnitudes, rounded up to an even width.
  localparam int SUM_W  = 36;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SCNT_W = $clog2(ROOT_W);

  action_t                   item_action;
  logic signed [ANGLE_W-1:0] cur  [NUM_JOINTS];
  logic signed [ANGLE_W-1:0] prev [NUM_JOINTS];
  logic [SEC_W-1:0]          item_sec;
  logic [NSEC_W-1:0]         item_nsec;

  logic [JIDX_W-1:0] jidx;
  logic [SQ_W-1:0]   prod;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  x_sh;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [SCNT_W-1:0] scnt;

  logic               have_prev;
  logic [LEN_W-1:0]   length_sum;
  logic [TALLY_W-1:0] tally;

  logic take_fire;
  logic emit_fire;
  logic out_busy;

  logic [ANGLE_W:0]   diff;
  logic [ANGLE_W:0]   diff_neg;
  logic [ANGLE_W-1:0] mag;
  logic [SQ_W-1:0]    sq_val;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [LEN_W:0]     len_wide;

  assign out_busy  = out_valid && out_stall;
  assign take_fire = ctrl.take && in_valid;
  assign emit_fire = ctrl.emit && !out_busy;

  // Absolute joint delta and its square for the joint under the index.
  assign diff     = {cur[jidx][ANGLE_W-1], cur[jidx]} - {prev[jidx][ANGLE_W-1], prev[jidx]};
  assign diff_neg = ~diff + 1'b1;
  assign mag      = diff[ANGLE_W] ? diff_neg[ANGLE_W-1:0] : diff[ANGLE_W-1:0];
  assign sq_val   = SQ_W'(mag) * SQ_W'(mag);

  // One root bit per step: bring down two radicand bits, try root*4+1.
  assign rem_sh   = {rem[REM_W-3:0], x_sh[SUM_W-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign len_wide = {1'b0, length_sum} + (LEN_W + 1)'(root);

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_cur
    if (j < JOINT_FIELDS) begin : g_field
      always_ff @(posedge clk) begin
        if (take_fire) begin
          cur[j] <= joint_pos[j];
        end
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        if (take_fire) begin
          cur[j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_fire) begin
      item_action <= action_t'(action);
      item_sec    <= time_sec;
      item_nsec   <= time_nsec;
    end
    if (ctrl.commit) begin
      prev <= cur;
    end
    if (ctrl.sq_init) begin
      x_sh <= acc;
    end else if (ctrl.sq_step) begin
      x_sh <= {x_sh[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jidx       <= '0;
      prod       <= '0;
      acc        <= '0;
      rem        <= '0;
      root       <= '0;
      scnt       <= '0;
      have_prev  <= 1'b0;
      length_sum <= '0;
      tally      <= '0;
    end else begin
      if (take_fire) begin
        jidx <= '0;
        prod <= '0;
        acc  <= '0;
      end else begin
        if (ctrl.mul) begin
          prod <= sq_val;
          if (jidx != JIDX_W'(NUM_JOINTS - 1)) begin
            jidx <= jidx + 1'b1;
          end
        end
        if (ctrl.acc_add) begin
          acc <= acc + SUM_W'(prod);
        end
      end
      if (ctrl.sq_init) begin
        rem  <= '0;
        root <= '0;
        scnt <= '0;
      end else if (ctrl.sq_step) begin
        scnt <= scnt + 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      if (emit_fire) begin
        have_prev  <= 1'b0;
        length_sum <= '0;
        tally      <= '0;
      end else begin
        if (ctrl.len_add) begin
          length_sum <= len_wide[LEN_W] ? '1 : len_wide[LEN_W-1:0];
        end
        if (ctrl.commit) begin
          have_prev <= 1'b1;
          if (tally != '1) begin
            tally <= tally + 1'b1;
          end
        end
      end
    end
  end

  // Result register; it frees the sequencer as soon as the word is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit_fire) begin
      if (item_action == ACT_LAST) begin
        valid_res     <= 1'b1;
        point_total   <= tally;
        duration_sec  <= item_sec;
        duration_nsec <= item_nsec;
        path_length   <= length_sum;
      end else begin
        valid_res     <= 1'b0;
        point_total   <= '0;
        duration_sec  <= '0;
        duration_nsec <= '0;
        path_length   <= '0;
      end
    end
  end

  assign status.item_valid = in_valid;
  assign status.action     = item_action;
  assign status.have_prev  = have_prev;
  assign status.joint_last = (jidx == JIDX_W'(NUM_JOINTS - 1));
  assign status.sqrt_last  = (scnt == SCNT_W'(ROOT_W - 1));
  assign status.out_busy   = out_busy;

  `JPLA_ASSERT_IMP(a_tally_with_prev, have_prev, tally != '0,
    "previous point held with zero point count")
  `JPLA_ASSERT_IMP(a_sqrt_remainder, 1'b1, rem <= REM_W'(root) + REM_W'(root),
    "square root remainder out of bound")
  `JPLA_ASSERT_NEXT(a_length_monotonic, !emit_fire, length_sum >= $past(length_sum),
    "path length decreased without a trajectory end")

endmodule

### rtl/joint_path_length_accumulator_core.sv
// Top level of the joint-space path length accumulator.
// Each input word is one trajectory point: the angles of up to six joints and a time stamp.
// For every point after the first of a trajectory the block adds the floored Euclidean
// distance to the previous point to a saturating path length, and on a last-point word it
// returns the point count, the last time stamp and the path length; an empty-trajectory
// word returns an all-zero word. Work is done by a microcoded sequencer over one 16x16
// multiplier and a one-bit-per-cycle square root, one word at a time: a new word is
// taken only once the program for the previous word has returned to its wait step. An
// empty-trajectory word skips the distance steps, as does the first point of a trajectory.
// The sequencer is back to accepting as soon as a result is loaded into the output
// register, so a stalled result only holds up the next result, not the next point.
module joint_path_length_accumulator_core
  import jpla_pkg::*;
#(
  parameter int NUM_JOINTS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                action,
  input  logic signed [ANGLE_W-1:0] joint_pos_0,
  input  logic signed [ANGLE_W-1:0] joint_pos_1,
  input  logic signed [ANGLE_W-1:0] joint_pos_2,
  input  logic signed [ANGLE_W-1:0] joint_pos_3,
  input  logic signed [ANGLE_W-1:0] joint_pos_4,
  input  logic signed [ANGLE_W-1:0] joint_pos_5,
  input  logic [SEC_W-1:0]          time_sec,
  input  logic [NSEC_W-1:0]         time_nsec,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      valid_res,
  output logic [TALLY_W-1:0]        point_total,
  output logic [SEC_W-1:0]          duration_sec,
  output logic [NSEC_W-1:0]         duration_nsec,
  output logic [LEN_W-1:0]          path_length
);

  logic signed [ANGLE_W-1:0] joint_pos [JOINT_FIELDS];
  dp_ctrl_t                  ctrl;
  dp_status_t                status;

  assign joint_pos[0] = joint_pos_0;
  assign joint_pos[1] = joint_pos_1;
  assign joint_pos[2] = joint_pos_2;
  assign joint_pos[3] = joint_pos_3;
  assign joint_pos[4] = joint_pos_4;
  assign joint_pos[5] = joint_pos_5;

  // A word is taken only at the program's wait step.
  assign in_stall = !ctrl.take;

  jpla_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  jpla_datapath #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .action        (action),
    .joint_pos     (joint_pos),
    .time_sec      (time_sec),
    .time_nsec     (time_nsec),
    .ctrl          (ctrl),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valid_res     (valid_res),
    .point_total   (point_total),
    .duration_sec  (duration_sec),
    .duration_nsec (duration_nsec),
    .path_length   (path_length)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the joint path length accumulator core.
`timescale 1ns / 1ps

module tb;
  import jpla_pkg::*;

  localparam int          RANDOM_WORDS = 1900;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [1:0]                       act;
    logic [JOINT_FIELDS-1:0][ANGLE_W-1:0] jp;
    logic [SEC_W-1:0]                 sec;
    logic [NSEC_W-1:0]                nsec;
  } point_word_t;

  typedef struct packed {
    logic               valid;
    logic [TALLY_W-1:0] total;
    logic [SEC_W-1:0]   sec;
    logic [NSEC_W-1:0]  nsec;
    logic [LEN_W-1:0]   len;
  } traj_report_t;

  typedef struct {
    point_word_t  w;
    bit           fixed;
    traj_report_t want;
  } stim_row_t;

  localparam traj_report_t NO_REPORT = '0;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                action;
  logic signed [ANGLE_W-1:0] joint_pos_0;
  logic signed [ANGLE_W-1:0] joint_pos_1;
  logic signed [ANGLE_W-1:0] joint_pos_2;
  logic signed [ANGLE_W-1:0] joint_pos_3;
  logic signed [ANGLE_W-1:0] joint_pos_4;
  logic signed [ANGLE_W-1:0] joint_pos_5;
  logic [SEC_W-1:0]          time_sec;
  logic [NSEC_W-1:0]         time_nsec;
  logic                      out_valid;
  logic                      out_stall;
  logic                      valid_res;
  logic [TALLY_W-1:0]        point_total;
  logic [SEC_W-1:0]          duration_sec;
  logic [NSEC_W-1:0]         duration_nsec;
  logic [LEN_W-1:0]          path_length;

  joint_path_length_accumulator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .joint_pos_0  (joint_pos_0),
    .joint_pos_1  (joint_pos_1),
    .joint_pos_2  (joint_pos_2),
    .joint_pos_3  (joint_pos_3),
    .joint_pos_4  (joint_pos_4),
    .joint_pos_5  (joint_pos_5),
    .time_sec     (time_sec),
    .time_nsec    (time_nsec),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .valid_res    (valid_res),
    .point_total  (point_total),
    .duration_sec (duration_sec),
    .duration_nsec(duration_nsec),
    .path_length  (path_length)
  );

  // Predicted trajectory state.
  logic [JOINT_FIELDS-1:0][ANGLE_W-1:0] prev_angle;
  bit                                   traj_open;
  logic [LEN_W-1:0]                     len_acc;
  logic [TALLY_W-1:0]                   pt_count;

  traj_report_t reports_due[$];
  stim_row_t    stim_rows[$];
  int           fault_count = 0;
  int unsigned  cycle_count = 0;
  int           burst_left  = 0;
  bit           steady      = 0;
  bit           hold_active = 0;
  event         hold_go;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("joint_path_length_accumulator_core verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] floor_root(input longint unsigned x);
    logic [31:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 19; i >= 0; i--) begin
      trial = {32'd0, r | (32'd1 << i)};
      if (trial * trial <= x) r = trial[31:0];
    end
    return r;
  endfunction

  task automatic restart_trip();
    traj_open = 0;
    len_acc   = '0;
    pt_count  = '0;
  endtask

  task automatic accumulate_path(input point_word_t w, output bit emits,
                                 output traj_report_t rep);
    longint unsigned     sq;
    logic signed [17:0]  d;
    logic [LEN_W:0]      sum;
    emits = 0;
    rep   = '0;
    case (w.act)
      ACT_POINT, ACT_LAST: begin
        if (traj_open) begin
          sq = 0;
          for (int j = 0; j < JOINT_FIELDS; j++) begin
            d  = $signed({w.jp[j][ANGLE_W-1], w.jp[j]}) -
                 $signed({prev_angle[j][ANGLE_W-1], prev_angle[j]});
            sq += longint'(d) * longint'(d);
          end
          sum     = {1'b0, len_acc} + {1'b0, floor_root(sq)};
          len_acc = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
        end
        prev_angle = w.jp;
        traj_open  = 1;
        if (pt_count != '1) pt_count++;
        if (w.act == ACT_LAST) begin
          emits = 1;
          rep   = '{1'b1, pt_count, w.sec, w.nsec, len_acc};
          restart_trip();
        end
      end
      ACT_EMPTY: begin
        emits = 1;
        restart_trip();
      end
      default: ;
    endcase
  endtask

  // Offers one word from a falling edge and returns at the falling edge after it is taken.
  task automatic send_word(input point_word_t w, input bit fixed, input traj_report_t want);
    int           gap;
    bit           emits;
    traj_report_t rep;
    if (!steady) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        gap = $urandom_range(0, 6);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    action      = w.act;
    joint_pos_0 = w.jp[0];
    joint_pos_1 = w.jp[1];
    joint_pos_2 = w.jp[2];
    joint_pos_3 = w.jp[3];
    joint_pos_4 = w.jp[4];
    joint_pos_5 = w.jp[5];
    time_sec    = w.sec;
    time_nsec   = w.nsec;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    accumulate_path(w, emits, rep);
    if (emits) reports_due.insert(reports_due.size(), fixed ? want : rep);
    @(negedge clk);
  endtask

  task automatic settle_reports();
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    // An ordinary point may still be in flight after the last report.
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic point_word_t uniform_word(input logic [1:0] a, input logic [15:0] ang,
                                               input logic [15:0] s, input logic [29:0] ns);
    point_word_t w;
    w.act = a;
    for (int j = 0; j < JOINT_FIELDS; j++) w.jp[j] = ang;
    w.sec  = s;
    w.nsec = ns;
    return w;
  endfunction

  function automatic logic [15:0] pick_angle(input logic [15:0] near);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6, 7: return near + 16'($urandom_range(0, 512)) - 16'd256;
      8:          return 16'h7FFF;
      default:    return 16'h8000;
    endcase
  endfunction

  function automatic point_word_t random_word(input logic [1:0] a, input point_word_t near);
    point_word_t w;
    w.act = a;
    for (int j = 0; j < JOINT_FIELDS; j++) w.jp[j] = pick_angle(near.jp[j]);
    w.sec  = 16'($urandom_range(0, 65535));
    w.nsec = ($urandom_range(0, 9) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
    return w;
  endfunction

  task automatic add_row(input point_word_t w, input bit fixed, input traj_report_t want);
    stim_row_t row;
    row.w     = w;
    row.fixed = fixed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Long output hold-off, counted here so the sender keeps offering words meanwhile.
  initial begin
    forever begin
      @(hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active = 1'b0;
    end
  end

  initial begin : rx_pattern
    int mode;
    int span;
    int period;
    int phase;
    bit pat;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(30, 300);
      period = $urandom_range(2, 12);
      phase  = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       pat = 1'b0;
          1:       pat = ($urandom_range(0, 9) < 3);
          2:       pat = ($urandom_range(0, 9) < 7);
          default: pat = ((phase % period) < period / 2);
        endcase
        phase++;
        out_stall = hold_active || pat;
      end
    end
  end

  always @(posedge clk) begin : report_check
    traj_report_t got;
    traj_report_t want;
    bit           bad;
    if (!rst && out_valid && !out_stall) begin
      got = '{valid_res, point_total, duration_sec, duration_nsec, path_length};
      if (reports_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected report: valid %0d total %0d sec %0d nsec %0d len %0d",
                   got.valid, got.total, got.sec, got.nsec, got.len);
      end else begin
        want = reports_due.pop_front();
        bad  = (got.valid !== want.valid) || (got.total !== want.total) ||
               (got.sec !== want.sec) || (got.nsec !== want.nsec) || (got.len !== want.len);
        if (bad) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("report mismatch (expected / actual):");
            $display("  valid %0d / %0d  total %0d / %0d", want.valid, got.valid,
                     want.total, got.total);
            $display("  sec %0d / %0d  nsec %0d / %0d  len %0d / %0d", want.sec, got.sec,
                     want.nsec, got.nsec, want.len, got.len);
          end
        end
      end
    end
  end

  initial begin : stimulus
    point_word_t w;
    point_word_t recent;
    logic [1:0]  act;
    int          sent;
    int          n;
    int          kind;
    bit          held;
    bit          paused;

    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    action      = ACT_POINT;
    joint_pos_0 = '0;
    joint_pos_1 = '0;
    joint_pos_2 = '0;
    joint_pos_3 = '0;
    joint_pos_4 = '0;
    joint_pos_5 = '0;
    time_sec    = '0;
    time_nsec   = '0;
    prev_angle  = '0;
    restart_trip();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: empty trajectory, single points, extremes, ignored action,
    // one joint moving at a time, and an empty word cutting a trajectory short.
    add_row(uniform_word(ACT_EMPTY, 16'h1234, 16'd7, 30'd9), 1, NO_REPORT);
    add_row(uniform_word(ACT_LAST, 16'h7FFF, 16'hFFFF, 30'h3FFF_FFFF), 1,
            '{1'b1, 16'd1, 16'hFFFF, 30'h3FFF_FFFF, 32'd0});
    add_row(uniform_word(ACT_UNUSED, 16'h3039, 16'd5, 30'd5), 0, NO_REPORT);
    add_row(uniform_word(ACT_POINT, 16'h8000, 16'd0, 30'd0), 0, NO_REPORT);
    // Full-scale swing on every joint: floor(65535 * sqrt(6)).
    add_row(uniform_word(ACT_LAST, 16'h7FFF, 16'd1, 30'd999999999), 1,
            '{1'b1, 16'd2, 16'd1, 30'd999999999, 32'd160527});
    add_row(uniform_word(ACT_POINT, 16'h0000, 16'd2, 30'd100), 0, NO_REPORT);
    for (int j = 0; j < JOINT_FIELDS; j++) begin
      w = uniform_word(ACT_POINT, 16'h0000, 16'(3 + j), 30'(1000 * j));
      w.jp[j] = 16'(4096 * (j + 1) - 1);
      add_row(w, 0, NO_REPORT);
    end
    add_row(uniform_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 30'h3FFF_FFFF), 0, NO_REPORT);
    add_row(uniform_word(ACT_LAST, 16'h0000, 16'd10, 30'd500000000), 0, NO_REPORT);
    add_row(uniform_word(ACT_POINT, 16'd100, 16'd11, 30'd1), 0, NO_REPORT);
    add_row(uniform_word(ACT_POINT, 16'hFF9C, 16'd12, 30'd2), 0, NO_REPORT);
    add_row(uniform_word(ACT_EMPTY, 16'h0000, 16'hFFFF, 30'h3FFF_FFFF), 1, NO_REPORT);
    w = uniform_word(ACT_POINT, 16'h7FFF, 16'd13, 30'd3);
    w.jp[1] = 16'h8000;
    w.jp[3] = 16'h8000;
    w.jp[5] = 16'h8000;
    add_row(w, 0, NO_REPORT);
    w = uniform_word(ACT_LAST, 16'h8000, 16'd14, 30'd4);
    w.jp[1] = 16'h7FFF;
    w.jp[3] = 16'h7FFF;
    w.jp[5] = 16'h7FFF;
    add_row(w, 0, NO_REPORT);
    add_row(uniform_word(ACT_LAST, 16'hFFFF, 16'd0, 30'd0), 1,
            '{1'b1, 16'd1, 16'd0, 30'd0, 32'd0});
    add_row(uniform_word(ACT_EMPTY, 16'h5555, 16'h5555, 30'h1555_5555), 1, NO_REPORT);

    for (int i = 0; i < stim_rows.size(); i++)
      send_word(stim_rows[i].w, stim_rows[i].fixed, stim_rows[i].want);
    settle_reports();

    recent = '0;
    sent   = 0;
    held   = 0;
    paused = 0;
    while (sent < RANDOM_WORDS) begin
      if (!held && sent > 600) begin
        // Results back up behind a stalled output until the input word stalls too.
        held = 1;
        -> hold_go;
        steady = 1;
        for (int k = 0; k < 12; k++) begin
          act    = (k % 3 == 2) ? ACT_EMPTY : ((k % 3 == 1) ? ACT_LAST : ACT_POINT);
          recent = random_word(act, recent);
          send_word(recent, 0, NO_REPORT);
          sent++;
        end
        steady = 0;
      end
      if (!paused && sent > 1200) begin
        paused = 1;
        settle_reports();
      end
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        recent = random_word(ACT_EMPTY, recent);
        send_word(recent, 0, NO_REPORT);
        sent++;
      end else if (kind < 10) begin
        recent = random_word(ACT_UNUSED, recent);
        send_word(recent, 0, NO_REPORT);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          act = (i == n - 1) ? ACT_LAST : ACT_POINT;
          // Now and then a trajectory is cut off by an empty word instead.
          if (i == n - 1 && $urandom_range(0, 19) == 0) act = ACT_EMPTY;
          recent = random_word(act, recent);
          send_word(recent, 0, NO_REPORT);
          sent++;
        end
      end
    end
    settle_reports();

    if (fault_count == 0 && reports_due.size() == 0)
      $display("joint_path_length_accumulator_core verification clean");
    else
      $display("joint_path_length_accumulator_core verification failed");
    $finish;
  end

endmodule
